// File: rtl/rkfa_pkg.sv
// ----------------------------------------------------------------------------
// rkfa_pkg: shared types and constants for the key free-list allocator
// Request codes, status codes, default sizes.
// ----------------------------------------------------------------------------
package rkfa_pkg;
  localparam int KEY_BITS_DEF   = 24;
  localparam int FREE_DEPTH_DEF = 64;
  localparam int NUM_SETS_DEF   = 5;
  localparam int REQ_W          = 3;
  localparam int SEL_W          = 3;
  localparam int STAT_W         = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC  = 3'd0,
    REQ_FREE   = 3'd1,
    REQ_FREE_L = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_TEST   = 3'd4,
    REQ_NEXT   = 3'd5,
    REQ_PREV   = 3'd6,
    REQ_CLAIM  = 3'd7
  } req_t;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_KEY = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_ROOM = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_SET = 3'd4;
endpackage

// File: rtl/record_key_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// record_key_free_list_allocator_top: multi-set key allocator with free list
// Sorted free list held in a chain of cells, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake            | Payload
// in_     | in  | in_valid / in_ready  | req_type, set_sel, key
// out_    | out | out_valid / out_ready| key_out, done_res, status,
//         |     |                      | in_use_count, high_mark, max_high_mark
// One transaction at a time: from acceptance to the next acceptance the block
// passes the accept state, the scan (locate, insert point, search; skipped for a
// bad set), a move state on insert or removal, the global maximum pass over all
// sets and the result state.
// Insert and removal shift all entries above the position at once, in the move state.
// Reset clears marks to 1 and counts to 0; list contents need no clearing.
// A stalled result holds the block; in_ready rises when the result is taken.
// ----------------------------------------------------------------------------
module record_key_free_list_allocator_top #(
  parameter int KEY_BITS   = rkfa_pkg::KEY_BITS_DEF,
  parameter int FREE_DEPTH = rkfa_pkg::FREE_DEPTH_DEF,
  parameter int NUM_SETS   = rkfa_pkg::NUM_SETS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rkfa_pkg::REQ_W-1:0]    in_req_type,
  input  logic [rkfa_pkg::SEL_W-1:0]    in_set_sel,
  input  logic [KEY_BITS-1:0]           in_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [KEY_BITS-1:0]           out_key_out,
  output logic                          out_done_res,
  output logic [rkfa_pkg::STAT_W-1:0]   out_status,
  output logic [KEY_BITS-1:0]           out_in_use_count,
  output logic [KEY_BITS:0]             out_high_mark,
  output logic [KEY_BITS:0]             out_max_high_mark
);
  import rkfa_pkg::*;

  localparam int CW  = $clog2(FREE_DEPTH + 1);
  localparam int IW  = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int MW  = KEY_BITS + 1;
  localparam int SW  = $clog2(NUM_SETS + 1);
  localparam logic [MW-1:0] MARK_TOP = {1'b1, {KEY_BITS{1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MOVE, S_MAX, S_OUT} state_t;

  state_t              state_r;
  req_t                req_r;
  logic [SW-1:0]       sel_r;
  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] k_r;          // running search key
  logic [CW-1:0]       idx_r;        // scan position
  logic [CW-1:0]       pos_r;        // found / insert position
  logic                hit_r;
  logic [MW-1:0]       mark_r [NUM_SETS];
  logic [CW-1:0]       cnt_r  [NUM_SETS];
  logic [MW-1:0]       mx_r;
  logic [SW-1:0]       mi_r;
  logic [KEY_BITS-1:0] kout_r;
  logic                done_r;
  logic [STAT_W-1:0]   stat_r;

  // ---- cell chain ----
  logic [KEY_BITS-1:0] ck [FREE_DEPTH];
  logic [FREE_DEPTH-1:0] c_ld, c_shl, c_shr;
  logic [SW-1:0]       csel;
  assign csel = sel_r;

  genvar g;
  generate
    for (g = 0; g < FREE_DEPTH; g++) begin : g_cell
      rkfa_cell #(.KEY_BITS(KEY_BITS), .NUM_SETS(NUM_SETS), .SET_W(SW)) u_cell (
        .clk(clk), .sel(csel), .ld(c_ld[g]), .shl(c_shl[g]), .shr(c_shr[g]),
        .ins_key(key_r),
        .up_key((g + 1 < FREE_DEPTH) ? ck[(g + 1) % FREE_DEPTH] : ck[g]),
        .dn_key((g > 0) ? ck[(g + FREE_DEPTH - 1) % FREE_DEPTH] : ck[g]),
        .key_o(ck[g]));
    end
  endgenerate

  // current set view
  logic [MW-1:0]       mark;
  logic [CW-1:0]       n;
  logic [KEY_BITS-1:0] cur;
  logic                in_rng;
  assign mark   = mark_r[sel_r[SW-1:0] < NUM_SETS ? sel_r : '0];
  assign n      = cnt_r[sel_r < NUM_SETS ? sel_r : '0];
  assign in_rng = idx_r < n;
  assign cur    = ck[idx_r[IW-1:0]];

  // move controls: insert at pos (shift right above), remove at pos (shift left)
  always_comb begin
    c_ld = '0; c_shl = '0; c_shr = '0;
    if (state_r == S_MOVE && hit_r) begin
      for (int i = 0; i < FREE_DEPTH; i++) begin
        if (req_r == REQ_REMOVE) begin
          c_shl[i] = (CW'(i) >= pos_r) && (CW'(i + 1) < n);
        end else begin
          c_ld[i]  = (CW'(i) == pos_r);
          c_shr[i] = (CW'(i) > pos_r) && (CW'(i) <= n);
        end
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // key plus one at mark width, so the top key still meets a full mark
  logic [MW-1:0] kp1;
  assign kp1 = {1'b0, key_r} + MW'(1);

  // ---- controller ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int s = 0; s < NUM_SETS; s++) begin
        mark_r[s] <= MW'(1);
        cnt_r[s]  <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r  <= req_t'(in_req_type);
            key_r  <= in_key;
            kout_r <= in_key;
            done_r <= 1'b0;
            hit_r  <= 1'b0;
            mx_r   <= '0;
            mi_r   <= '0;
            if ({1'b0, in_set_sel} >= (SEL_W + 1)'(NUM_SETS)) begin
              sel_r   <= '0;
              stat_r  <= ST_BAD_SET;
              idx_r   <= '0;
              state_r <= S_MAX;
            end else begin
              sel_r  <= SW'(in_set_sel);
              stat_r <= ST_OK;
              if (req_t'(in_req_type) == REQ_NEXT) begin
                k_r   <= in_key + KEY_BITS'(1);
                idx_r <= cnt_r[SW'(in_set_sel)];  // next walks from the end down
              end else begin
                idx_r <= '0;
                if (req_t'(in_req_type) == REQ_PREV) begin
                  if ({1'b0, in_key} > mark_r[SW'(in_set_sel)])
                    k_r <= KEY_BITS'(mark_r[SW'(in_set_sel)] - MW'(1));
                  else
                    k_r <= in_key - KEY_BITS'(1);
                end
              end
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          unique case (req_r)
            REQ_ALLOC: begin
              if (n != 0) begin
                kout_r <= ck[IW'(n - CW'(1))];
                cnt_r[sel_r] <= n - CW'(1);
                done_r <= 1'b1;
              end else if (mark < MARK_TOP) begin
                kout_r <= KEY_BITS'(mark);
                mark_r[sel_r] <= mark + MW'(1);
                done_r <= 1'b1;
              end else begin
                kout_r <= '0;
                stat_r <= ST_NO_ROOM;
              end
              state_r <= S_MAX;
            end
            REQ_CLAIM: begin
              if (key_r == '0) stat_r <= ST_BAD_KEY;
              else begin
                cnt_r[sel_r] <= '0;
                if ({1'b0, key_r} >= mark) mark_r[sel_r] <= {1'b0, key_r} + MW'(1);
                done_r <= 1'b1;
              end
              state_r <= S_MAX;
            end
            REQ_NEXT: begin
              // walk from smallest entry upward
              if (idx_r != '0 && ck[IW'(idx_r - CW'(1))] >= k_r) begin
                if (ck[IW'(idx_r - CW'(1))] == k_r) begin
                  k_r <= k_r + KEY_BITS'(1);
                  idx_r <= idx_r - CW'(1);
                end else idx_r <= '0;
              end else if (idx_r != '0 && ck[IW'(idx_r - CW'(1))] < k_r) begin
                idx_r <= idx_r - CW'(1);
              end else begin
                if ({1'b0, k_r} < mark) begin
                  kout_r <= k_r; done_r <= (k_r != '0);
                end else begin
                  kout_r <= '0; done_r <= 1'b0;
                end
                state_r <= S_MAX;
              end
            end
            REQ_PREV: begin
              if (key_r == '0) begin
                kout_r <= '0; state_r <= S_MAX;
              end else if (in_rng && k_r != '0 && cur >= k_r) begin
                if (cur == k_r) k_r <= k_r - KEY_BITS'(1);
                idx_r <= idx_r + CW'(1);
              end else begin
                kout_r <= k_r; done_r <= (k_r != '0); state_r <= S_MAX;
              end
            end
            default: begin
              // free, lenient free, remove, test: locate then find insert point
              if (key_r == '0) begin
                stat_r <= ST_BAD_KEY; state_r <= S_MAX;
              end else if ((req_r == REQ_FREE || req_r == REQ_FREE_L) &&
                           {1'b0, key_r} >= mark) begin
                stat_r <= ST_BAD_KEY; state_r <= S_MAX;
              end else if (in_rng && cur > key_r) begin
                idx_r <= idx_r + CW'(1);
              end else begin
                // list is sorted descending: first entry <= key decides
                pos_r <= idx_r;
                if (in_rng && cur == key_r) begin
                  if (req_r == REQ_REMOVE) begin
                    hit_r <= 1'b1; done_r <= 1'b1; state_r <= S_MOVE;
                  end else begin
                    if (req_r == REQ_FREE) stat_r <= ST_DUP;
                    state_r <= S_MAX;
                  end
                end else if (req_r == REQ_TEST) begin
                  done_r <= ({1'b0, key_r} < mark); state_r <= S_MAX;
                end else if (req_r == REQ_REMOVE) begin
                  state_r <= S_MAX;
                end else if (kp1 == mark) begin
                  mark_r[sel_r] <= mark - MW'(1); done_r <= 1'b1; state_r <= S_MAX;
                end else if (n >= CW'(FREE_DEPTH)) begin
                  stat_r <= ST_NO_ROOM; state_r <= S_MAX;
                end else begin
                  hit_r <= 1'b1; done_r <= 1'b1; state_r <= S_MOVE;
                end
              end
            end
          endcase
        end
        S_MOVE: begin
          if (req_r == REQ_REMOVE) cnt_r[sel_r] <= n - CW'(1);
          else                     cnt_r[sel_r] <= n + CW'(1);
          state_r <= S_MAX;
        end
        S_MAX: begin
          // one set per cycle for the global maximum
          if (mark_r[mi_r] > mx_r) mx_r <= mark_r[mi_r];
          if (mi_r == SW'(NUM_SETS - 1)) state_r <= S_OUT;
          else mi_r <= mi_r + SW'(1);
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic bad;
  assign bad               = (stat_r == ST_BAD_SET);
  assign out_key_out       = kout_r;
  assign out_done_res      = done_r;
  assign out_status        = stat_r;
  assign out_high_mark     = bad ? '0 : mark;
  assign out_in_use_count  = bad ? '0 : KEY_BITS'(mark - MW'(n) - MW'(1));
  assign out_max_high_mark = mx_r;
endmodule

// File: rtl/rkfa_cell.sv
// ----------------------------------------------------------------------------
// rkfa_cell: one entry of the free-list chain
// Holds one key per set; takes a shift from either neighbor on command.
// ----------------------------------------------------------------------------
module rkfa_cell #(
  parameter int KEY_BITS = rkfa_pkg::KEY_BITS_DEF,
  parameter int NUM_SETS = rkfa_pkg::NUM_SETS_DEF,
  parameter int SET_W    = 3
) (
  input  logic                clk,
  input  logic [SET_W-1:0]    sel,
  input  logic                ld,       // load from ins_key
  input  logic                shl,      // take from upper neighbor (index+1)
  input  logic                shr,      // take from lower neighbor (index-1)
  input  logic [KEY_BITS-1:0] ins_key,
  input  logic [KEY_BITS-1:0] up_key,
  input  logic [KEY_BITS-1:0] dn_key,
  output logic [KEY_BITS-1:0] key_o
);
  logic [KEY_BITS-1:0] mem_r [NUM_SETS];

  // read the selected set, write it back on a move
  assign key_o = mem_r[sel];
  always_ff @(posedge clk) begin
    if (ld) begin
      mem_r[sel] <= ins_key;
    end else if (shl) begin
      mem_r[sel] <= up_key;
    end else if (shr) begin
      mem_r[sel] <= dn_key;
    end
  end
endmodule

// File: rtl/rkfa_checker.sv
// ----------------------------------------------------------------------------
// rkfa_checker: port-level checks for the allocator
// Handshake and result consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
module rkfa_checker #(
  parameter int KEY_BITS = rkfa_pkg::KEY_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_done_res,
  input logic [2:0]          out_status,
  input logic [KEY_BITS:0]   out_high_mark,
  input logic [KEY_BITS:0]   out_max_high_mark
);
  import rkfa_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_high_mark))
    else $error("result dropped while stalled");
  // never accept while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input ready with result pending");
  // max mark bounds the addressed mark
  a_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_max_high_mark >= out_high_mark)
    else $error("max mark below set mark");
  // bad-key and bad-set errors never report done
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BAD_KEY || out_status == ST_BAD_SET) |-> !out_done_res)
    else $error("error with done");
endmodule

bind record_key_free_list_allocator_top rkfa_checker #(.KEY_BITS(KEY_BITS)) u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_done_res(out_done_res), .out_status(out_status),
  .out_high_mark(out_high_mark), .out_max_high_mark(out_max_high_mark));

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for record_key_free_list_allocator_top
// Drives requests over the in_ channel with random sender gaps and receiver
// stalls. Expected results come from an in-bench model of the five key sets
// and are compared field by field against every out_ transaction.
// ----------------------------------------------------------------------------
module testbench;
  import rkfa_pkg::*;

  localparam int KB    = 24;
  localparam int DEPTH = 64;
  localparam int SETS  = 5;
  localparam int unsigned KMASK = 32'h00FF_FFFF;
  localparam int unsigned MTOP  = 32'h0100_0000;
  localparam int unsigned MMASK = 32'h01FF_FFFF;

  typedef struct packed {
    logic [KB-1:0]     key_out;
    logic              done_res;
    logic [STAT_W-1:0] status;
    logic [KB-1:0]     in_use;
    logic [KB:0]       mark;
    logic [KB:0]       max_mark;
  } alloc_result_t;

  // Key-set model plus queue of pending results
  class key_set_scoreboard;
    int unsigned   mark[SETS];
    int unsigned   freed[SETS][DEPTH];
    int unsigned   cnt[SETS];
    alloc_result_t pending[$];

    function new();
      for (int s = 0; s < SETS; s++) begin
        mark[s] = 1;
        cnt[s]  = 0;
      end
    endfunction

    // Apply one accepted request and queue its result
    function void note_request(req_t req, logic [2:0] sel, logic [KB-1:0] key_in);
      alloc_result_t r;
      int unsigned key, kout, m, n, k, pos, mx;
      logic done;
      logic [STAT_W-1:0] st;
      key  = 32'(key_in);
      kout = key;
      done = 0;
      st   = ST_OK;
      r    = '0;
      if (sel >= SETS) begin
        st = ST_BAD_SET;
      end else begin
        m = mark[sel];
        n = cnt[sel];
        case (req)
          REQ_ALLOC: begin
            if (n > 0) begin
              kout = freed[sel][n-1];
              n--;
              done = 1;
            end else if (m < MTOP) begin
              kout = m;
              m++;
              done = 1;
            end else begin
              kout = 0;
              st = ST_NO_ROOM;
            end
          end
          REQ_FREE, REQ_FREE_L: begin
            pos = n;
            for (int i = 0; i < n; i++) if (freed[sel][i] == key && pos == n) pos = i;
            if (key == 0 || key >= m) st = ST_BAD_KEY;
            else if (pos < n) begin
              if (req == REQ_FREE) st = ST_DUP;
            end else if (key + 1 == m) begin
              m--;
              done = 1;
            end else if (n >= DEPTH) st = ST_NO_ROOM;
            else begin
              pos = 0;
              while (pos < n && freed[sel][pos] > key) pos++;
              for (int i = n; i > pos; i--) freed[sel][i] = freed[sel][i-1];
              freed[sel][pos] = key;
              n++;
              done = 1;
            end
          end
          REQ_REMOVE: begin
            if (key == 0) st = ST_BAD_KEY;
            else begin
              pos = n;
              for (int i = 0; i < n; i++) if (freed[sel][i] == key && pos == n) pos = i;
              if (pos < n) begin
                for (int i = pos; i + 1 < n; i++) freed[sel][i] = freed[sel][i+1];
                n--;
                done = 1;
              end
            end
          end
          REQ_TEST: begin
            if (key == 0) st = ST_BAD_KEY;
            else begin
              done = (key < m);
              for (int i = 0; i < n; i++) if (freed[sel][i] == key) done = 0;
            end
          end
          REQ_NEXT: begin
            // walk up past consecutive freed keys
            k = key + 1;
            for (int i = n; i > 0; i--) begin
              if (freed[sel][i-1] == k) k++;
              else if (freed[sel][i-1] > k) break;
            end
            kout = (k < m) ? k : 0;
            done = (kout != 0);
          end
          REQ_PREV: begin
            if (key == 0) kout = 0;
            else begin
              k = key - 1;
              if (k >= m) k = m - 1;
              for (int i = 0; i < n && k > 0; i++) begin
                if (freed[sel][i] == k) k--;
                else if (freed[sel][i] < k) break;
              end
              kout = k;
            end
            done = (kout != 0);
          end
          default: begin
            if (key == 0) st = ST_BAD_KEY;
            else begin
              n = 0;
              if (key >= m) m = key + 1;
              done = 1;
            end
          end
        endcase
        mark[sel] = m & MMASK;
        cnt[sel]  = n;
        r.mark    = (KB + 1)'(m & MMASK);
        r.in_use  = KB'((m - n - 1) & KMASK);
      end
      mx = 0;
      for (int s = 0; s < SETS; s++) if (mark[s] > mx) mx = mark[s];
      r.key_out  = KB'(kout & KMASK);
      r.done_res = done;
      r.status   = st;
      r.max_mark = (KB + 1)'(mx);
      pending.push_back(r);
    endfunction

    // Compare one result with the oldest pending one; empty string means match
    function string check_result(alloc_result_t got);
      alloc_result_t e;
      if (pending.size() == 0) return "result with nothing pending";
      e = pending.pop_front();
      if (got == e) return "";
      return $sformatf("got key %0h done %0d st %0d use %0h hm %0h mx %0h, exp %0h %0d %0d %0h %0h %0h",
        got.key_out, got.done_res, got.status, got.in_use, got.mark, got.max_mark,
        e.key_out, e.done_res, e.status, e.in_use, e.mark, e.max_mark);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [REQ_W-1:0]  in_req_type;
  logic [SEL_W-1:0]  in_set_sel;
  logic [KB-1:0]     in_key;
  logic              out_valid;
  logic              out_ready;
  logic [KB-1:0]     out_key_out;
  logic              out_done_res;
  logic [STAT_W-1:0] out_status;
  logic [KB-1:0]     out_in_use_count;
  logic [KB:0]       out_high_mark;
  logic [KB:0]       out_max_high_mark;

  key_set_scoreboard sb;
  int errors;
  int send_idle_pct;
  int recv_stall_pct;

  record_key_free_list_allocator_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_set_sel(in_set_sel), .in_key(in_key),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_key_out(out_key_out), .out_done_res(out_done_res), .out_status(out_status),
    .out_in_use_count(out_in_use_count), .out_high_mark(out_high_mark),
    .out_max_high_mark(out_max_high_mark)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

  task report(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  // Input monitor: each accepted transaction updates the model
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_request(req_t'(in_req_type), in_set_sel, in_key);
  end

  // Output monitor
  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && out_ready) begin
      msg = sb.check_result({out_key_out, out_done_res, out_status, out_in_use_count,
                             out_high_mark, out_max_high_mark});
      if (msg != "") report(msg);
    end
  end

  // Receiver back-pressure, held low through reset
  always @(negedge clk) begin
    out_ready <= rst_n ? ($urandom_range(99) >= recv_stall_pct) : 1'b0;
  end

  // Drive one request and hold it until accepted; called at a falling edge
  task send(req_t req, logic [2:0] sel, logic [KB-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_req_type = req;
    in_set_sel  = sel;
    in_key      = key;
    in_valid    = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Key near the addressed set's mark, a listed key, zero, or anything
  function logic [KB-1:0] pick_key(logic [2:0] sel, req_t req);
    int unsigned m, lo, r;
    m = (sel < SETS) ? sb.mark[sel] : 64;
    r = $urandom_range(99);
    if (r < 5) return KB'($urandom);
    if (r < 9) return '0;
    if (r < 35 && sel < SETS && sb.cnt[sel] > 0)
      return KB'(sb.freed[sel][$urandom_range(sb.cnt[sel] - 1)]);
    lo = (m > 80) ? m - 80 : 0;
    if (req == REQ_CLAIM) return KB'($urandom_range(m + 40, lo) & KMASK);
    return KB'($urandom_range(m + 1, lo) & KMASK);
  endfunction

  task random_items(int count);
    req_t req;
    logic [2:0] sel;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 25) req = REQ_ALLOC;
      else if (r < 50) req = REQ_FREE;
      else if (r < 58) req = REQ_FREE_L;
      else if (r < 66) req = REQ_REMOVE;
      else if (r < 76) req = REQ_TEST;
      else if (r < 85) req = REQ_NEXT;
      else if (r < 94) req = REQ_PREV;
      else req = REQ_CLAIM;
      sel = ($urandom_range(99) < 90) ? 3'($urandom_range(SETS - 1))
                                      : 3'($urandom_range(7, SETS));
      send(req, sel, pick_key(sel, req));
    end
  endtask

  initial begin
    sb = new();
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 0;
    in_valid = 0;
    in_req_type = REQ_ALLOC;
    in_set_sel = 0;
    in_key = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: each request type and corner case
    send(REQ_ALLOC, 0, 0);
    send(REQ_ALLOC, 0, 0);
    send(REQ_ALLOC, 0, 0);
    send(REQ_FREE, 0, 2);          // sorted insert
    send(REQ_FREE, 0, 2);          // duplicate, strict
    send(REQ_FREE_L, 0, 2);        // duplicate, lenient
    send(REQ_FREE, 0, 3);          // just below mark: lowers it
    send(REQ_FREE, 0, 0);          // zero key
    send(REQ_FREE, 0, 9);          // never issued
    send(REQ_TEST, 0, 1);
    send(REQ_TEST, 0, 2);
    send(REQ_TEST, 0, 0);
    send(REQ_NEXT, 0, 0);
    send(REQ_PREV, 0, 3);
    send(REQ_PREV, 0, 0);
    send(REQ_REMOVE, 0, 2);
    send(REQ_REMOVE, 0, 2);        // not listed
    send(REQ_REMOVE, 0, 0);
    send(REQ_CLAIM, 0, 0);
    send(REQ_CLAIM, 3, 24'hFF_FFFF); // mark to the top
    send(REQ_ALLOC, 3, 0);         // mark exhausted
    send(REQ_TEST, 3, 24'hFF_FFFF);
    send(REQ_NEXT, 3, 24'hFF_FFFF);
    send(REQ_ALLOC, 7, 24'hAA_5555); // bad set
    send(REQ_CLAIM, 5, 24'h55_AAAA);

    // Fill one list past capacity
    send(REQ_CLAIM, 2, 150);
    for (int k = 1; k <= 131; k += 2) send(REQ_FREE, 2, KB'(k));

    // Random traffic over idle/stall phases
    random_items(90);
    send_idle_pct = 75;
    random_items(90);
    send_idle_pct = 0;
    recv_stall_pct = 75;
    random_items(90);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    random_items(90);
    in_valid = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

// File: record_key_free_list_allocator_top.f
rtl/rkfa_pkg.sv
rtl/rkfa_cell.sv
rtl/record_key_free_list_allocator_top.sv
rtl/rkfa_checker.sv
test/testbench.sv
